// ===== sv/mrq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message ring queue package
// Shared constants and the command code type of the message ring queue.
// ----------------------------------------------------------------------------
package mrq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int MSG_WIDTH_DEFAULT = 32;

    localparam int CMD_W      = 2;
    localparam int LEN_W      = 5;
    localparam int PORT_MSG_W = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND = 2'd0,
        CMD_JAM  = 2'd1,
        CMD_RECV = 2'd2
    } cmd_t;

endpackage
`default_nettype wire

// ===== sv/mrq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message ring queue RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mrq_ram #(
    parameter int WIDTH = mrq_pkg::MSG_WIDTH_DEFAULT,
    parameter int DEPTH = mrq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== sv/message_ring_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message ring queue
// Bounded circular queue of message words with send, jam and receive commands.
// A result is registered and shown in the cycle after its command transfer.
// Throughput: one command per cycle while in_stall is low; the message RAM
// takes one write and one prefetch read of the next head slot each cycle, with
// write forwarding. Reset: queue length returns to 16, head and occupancy to
// zero; the RAM contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module message_ring_queue #(
    parameter int DEPTH     = mrq_pkg::DEPTH_DEFAULT,
    parameter int MSG_WIDTH = mrq_pkg::MSG_WIDTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [mrq_pkg::LEN_W-1:0]        cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [mrq_pkg::CMD_W-1:0]        cmd,
    input  wire logic [mrq_pkg::PORT_MSG_W-1:0]   message_in,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  status,
    output logic      [mrq_pkg::PORT_MSG_W-1:0]   message_out,
    output logic      [mrq_pkg::LEN_W-1:0]        occupancy
);

    localparam int IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LenW   = mrq_pkg::LEN_W;
    localparam int ArithW = ((IdxW > LenW) ? IdxW : LenW) + 1;
    localparam int PortW  = mrq_pkg::PORT_MSG_W;
    localparam int LenCap = (DEPTH > 31) ? 31 : DEPTH;

    logic [IdxW-1:0]      head_reg;
    logic [IdxW-1:0]      head_next;
    logic [LenW-1:0]      count_reg;
    logic [LenW-1:0]      count_next;
    logic [LenW-1:0]      qlen_reg;
    logic [LenW-1:0]      len;

    logic                 out_valid_reg;
    logic                 out_status_reg;
    logic [PortW-1:0]     out_msg_reg;
    logic [LenW-1:0]      out_occ_reg;

    logic                 fwd_valid_reg;
    logic [MSG_WIDTH-1:0] fwd_data_reg;

    logic                 in_fire;
    logic                 wr_en;
    logic [IdxW-1:0]      wr_addr;
    logic [MSG_WIDTH-1:0] wr_data;
    logic [MSG_WIDTH-1:0] rd_data;
    logic [MSG_WIDTH-1:0] pop_data;
    logic                 status_c;
    logic [PortW-1:0]     pop_msg_c;

    logic [ArithW-1:0]    head_ext;
    logic [ArithW-1:0]    len_ext;
    logic [ArithW-1:0]    tail_sum;
    logic [ArithW-1:0]    send_slot;
    logic [ArithW-1:0]    jam_slot;
    logic [ArithW-1:0]    recv_sum;
    logic [ArithW-1:0]    recv_slot;
    logic                 has_room;
    logic                 has_msg;

    assign len = (qlen_reg > LenW'(LenCap)) ? LenW'(LenCap) : qlen_reg;

    assign head_ext  = ArithW'(head_reg);
    assign len_ext   = ArithW'(len);
    assign tail_sum  = head_ext + ArithW'(count_reg);
    assign send_slot = (tail_sum >= len_ext) ? (tail_sum - len_ext) : tail_sum;
    assign jam_slot  = (head_reg == '0) ? (len_ext - ArithW'(1)) : (head_ext - ArithW'(1));
    assign recv_sum  = head_ext + ArithW'(1);
    assign recv_slot = (recv_sum >= len_ext) ? '0 : recv_sum;

    assign has_room = (count_reg < len);
    assign has_msg  = (count_reg != '0) && (len != '0);

    assign in_stall = out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;
    assign wr_data  = MSG_WIDTH'(message_in);
    assign pop_data = fwd_valid_reg ? fwd_data_reg : rd_data;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        status_c   = mrq_pkg::STATUS_ERR;
        pop_msg_c  = '0;
        if (cfg_write)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (in_fire)
        begin
            unique case (mrq_pkg::cmd_t'(cmd))
                mrq_pkg::CMD_SEND:
                begin
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = send_slot[IdxW-1:0];
                        count_next = count_reg + LenW'(1);
                        status_c   = mrq_pkg::STATUS_OK;
                    end
                end
                mrq_pkg::CMD_JAM:
                begin
                    if (has_room)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = jam_slot[IdxW-1:0];
                        head_next  = jam_slot[IdxW-1:0];
                        count_next = count_reg + LenW'(1);
                        status_c   = mrq_pkg::STATUS_OK;
                    end
                end
                mrq_pkg::CMD_RECV:
                begin
                    if (has_msg)
                    begin
                        pop_msg_c  = PortW'(pop_data);
                        head_next  = recv_slot[IdxW-1:0];
                        count_next = count_reg - LenW'(1);
                        status_c   = mrq_pkg::STATUS_OK;
                    end
                end
                default:
                begin
                    status_c = mrq_pkg::STATUS_ERR;
                end
            endcase
        end
    end

    mrq_ram #(
        .WIDTH (MSG_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            qlen_reg      <= mrq_pkg::LEN_RESET;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            fwd_valid_reg <= wr_en && (wr_addr == head_next);
            if (cfg_write)
            begin
                qlen_reg <= cfg_data;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wr_data;
        if (in_fire)
        begin
            out_status_reg <= status_c;
            out_msg_reg    <= pop_msg_c;
            out_occ_reg    <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign message_out = out_msg_reg;
    assign occupancy   = out_occ_reg;

    // The occupancy never exceeds the effective queue length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= len)
        else $error("occupancy exceeds queue length");

    // The head index stays inside the active ring.
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (head_ext < len_ext) || (head_reg == '0))
        else $error("head index outside the ring");

    // Every accepted command produces a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("result missing after command transfer");

    // The reported occupancy matches the internal count after the command.
    a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_write) |=> (out_occ_reg == count_reg))
        else $error("reported occupancy differs from count");

    // A failed command leaves the queue state untouched.
    a_error_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg_write && (status_c == mrq_pkg::STATUS_ERR))
            |=> ($stable(head_reg) && $stable(count_reg)))
        else $error("failed command changed queue state");

endmodule
`default_nettype wire
